// ===== rtl/audio_video_tag_rewriter_defines.svh =====
`ifndef AUDIO_VIDEO_TAG_REWRITER_DEFINES_SVH
`define AUDIO_VIDEO_TAG_REWRITER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define AVTR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("avtr assertion failed");

// Next-cycle implication, held off during reset.
`define AVTR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("avtr assertion failed");

`endif

// ===== rtl/avtr_pkg.sv =====
`default_nettype none

package avtr_pkg;

    localparam int unsigned AVTR_BYTE_W = 8;

    typedef struct packed {
        logic                   restart;
        logic                   last;
        logic [AVTR_BYTE_W-1:0] data;
    } avtr_item_t;

    typedef struct packed {
        logic                   last;
        logic [AVTR_BYTE_W-1:0] data;
    } avtr_result_t;

    localparam int unsigned AVTR_IN_W  = $bits(avtr_item_t);
    localparam int unsigned AVTR_OUT_W = $bits(avtr_result_t);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'd1,
        ST_LT    = 5'd2,
        ST_A     = 5'd3,
        ST_AU    = 5'd4,
        ST_AUD   = 5'd5,
        ST_V     = 5'd6,
        ST_VI    = 5'd7,
        ST_VID   = 5'd8,
        ST_NAME  = 5'd9,
        ST_BANG  = 5'd10,
        ST_CD_LB = 5'd11,
        ST_CD_C  = 5'd12,
        ST_CD_D  = 5'd13,
        ST_CD_A  = 5'd14,
        ST_CD_T  = 5'd15,
        ST_CD_A2 = 5'd16,
        ST_CDATA = 5'd17,
        ST_RB1   = 5'd18,
        ST_RB2   = 5'd19
    } avtr_state_t;

    localparam logic [AVTR_BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [AVTR_BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [AVTR_BYTE_W-1:0] CH_BANG  = 8'h21;
    localparam logic [AVTR_BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [AVTR_BYTE_W-1:0] CH_LB    = 8'h5B;
    localparam logic [AVTR_BYTE_W-1:0] CH_RB    = 8'h5D;
    localparam logic [AVTR_BYTE_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [AVTR_BYTE_W-1:0] CH_UC_C  = 8'h43;
    localparam logic [AVTR_BYTE_W-1:0] CH_UC_D  = 8'h44;
    localparam logic [AVTR_BYTE_W-1:0] CH_UC_T  = 8'h54;
    localparam logic [AVTR_BYTE_W-1:0] CH_A     = 8'h61;
    localparam logic [AVTR_BYTE_W-1:0] CH_D     = 8'h64;
    localparam logic [AVTR_BYTE_W-1:0] CH_E     = 8'h65;
    localparam logic [AVTR_BYTE_W-1:0] CH_I     = 8'h69;
    localparam logic [AVTR_BYTE_W-1:0] CH_O     = 8'h6F;
    localparam logic [AVTR_BYTE_W-1:0] CH_U     = 8'h75;
    localparam logic [AVTR_BYTE_W-1:0] CH_V     = 8'h76;
    localparam logic [AVTR_BYTE_W-1:0] CH_REPL  = 8'h5F;

endpackage

`default_nettype wire

// ===== rtl/avtr_stage.sv =====
`default_nettype none

module avtr_stage
    import avtr_pkg::*;
#(
    parameter int unsigned W = AVTR_IN_W
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [W-1:0] s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [W-1:0]      m_data
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    assign s_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            data_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/avtr_matcher.sv =====
`default_nettype none

`include "audio_video_tag_rewriter_defines.svh"

module avtr_matcher
    import avtr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire avtr_item_t   item,
    output avtr_result_t      result
);

    avtr_state_t state_reg;
    avtr_state_t state_next;
    avtr_state_t state_cur;

    assign state_cur = item.restart ? ST_IDLE : state_reg;

    always_comb
    begin
        state_next = state_cur;
        unique case (state_cur)
            ST_LT:
            begin
                priority if (item.data == CH_A)     state_next = ST_A;
                else if (item.data == CH_V)         state_next = ST_V;
                else if (item.data == CH_BANG)      state_next = ST_BANG;
                else if (item.data == CH_SLASH)     state_next = ST_LT;
                else                                state_next = ST_IDLE;
            end
            ST_A:     state_next = (item.data == CH_U)    ? ST_AU    : ST_IDLE;
            ST_AU:    state_next = (item.data == CH_D)    ? ST_AUD   : ST_IDLE;
            ST_AUD:   state_next = (item.data == CH_I)    ? ST_NAME  : ST_IDLE;
            ST_V:     state_next = (item.data == CH_I)    ? ST_VI    : ST_IDLE;
            ST_VI:    state_next = (item.data == CH_D)    ? ST_VID   : ST_IDLE;
            ST_VID:   state_next = (item.data == CH_E)    ? ST_NAME  : ST_IDLE;
            ST_NAME:  state_next = ST_IDLE;
            ST_BANG:  state_next = (item.data == CH_LB)   ? ST_CD_LB : ST_IDLE;
            ST_CD_LB: state_next = (item.data == CH_UC_C) ? ST_CD_C  : ST_IDLE;
            ST_CD_C:  state_next = (item.data == CH_UC_D) ? ST_CD_D  : ST_IDLE;
            ST_CD_D:  state_next = (item.data == CH_UC_A) ? ST_CD_A  : ST_IDLE;
            ST_CD_A:  state_next = (item.data == CH_UC_T) ? ST_CD_T  : ST_IDLE;
            ST_CD_T:  state_next = (item.data == CH_UC_A) ? ST_CD_A2 : ST_IDLE;
            ST_CD_A2: state_next = (item.data == CH_LB)   ? ST_CDATA : ST_IDLE;
            ST_CDATA: state_next = (item.data == CH_RB)   ? ST_RB1   : ST_CDATA;
            ST_RB1:   state_next = (item.data == CH_RB)   ? ST_RB2   : ST_CDATA;
            ST_RB2:   state_next = (item.data == CH_GT)   ? ST_IDLE  : ST_CDATA;
            default:  state_next = (item.data == CH_LT)   ? ST_LT    : ST_IDLE;
        endcase
    end

    always_comb
    begin
        result.last = item.last;
        result.data = item.data;
        if (state_cur == ST_NAME && item.data == CH_O)
        begin
            result.data = CH_REPL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    `AVTR_ASSERT_NEXT(a_hold_state, clk, rst_n, !advance, $stable(state_reg))
    `AVTR_ASSERT_NOW(a_only_o_rewritten, clk, rst_n, result.data != item.data,
        item.data == CH_O && state_cur == ST_NAME)
    `AVTR_ASSERT_NEXT(a_restart_idle, clk, rst_n,
        advance && item.restart && item.data != CH_LT, state_reg == ST_IDLE)
    `AVTR_ASSERT_NEXT(a_name_one_byte, clk, rst_n,
        advance && state_cur == ST_NAME, state_reg == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/audio_video_tag_rewriter.sv =====
// Markup byte-stream rewriter: one byte in, one byte out, in order. The 'o' that completes
// "<audio" or "<video" (any number of '/' after the '<') leaves as '_', every other byte
// passes unchanged, and nothing is matched inside a CDATA section. tuser set on an input
// restarts the matcher before that byte; tlast is carried through as the chunk marker.
// A byte passes through the input register, then the result register, on its way out,
// and one byte can be accepted every cycle while the output does not stall: the next-state
// update of the tag matcher between the two registers sets that rate. Stalls on the output
// propagate to the input ready combinationally through the two stages.
`default_nettype none

`include "audio_video_tag_rewriter_defines.svh"

module audio_video_tag_rewriter
    import avtr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [AVTR_BYTE_W-1:0] s_axis_tdata,   // in_byte
    input  wire logic                   s_axis_tuser,   // new_stream
    input  wire logic                   s_axis_tlast,   // chunk_last
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [AVTR_BYTE_W-1:0]      m_axis_tdata,   // out_byte
    output logic                        m_axis_tlast    // chunk_end
);

    avtr_item_t   in_item;
    avtr_item_t   held_item;
    avtr_result_t result;
    avtr_result_t out_result;
    logic         held_valid;
    logic         out_ready;

    assign in_item.restart = s_axis_tuser;
    assign in_item.last    = s_axis_tlast;
    assign in_item.data    = s_axis_tdata;

    avtr_stage #(
        .W (AVTR_IN_W)
    ) u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (in_item),
        .m_valid (held_valid),
        .m_ready (out_ready),
        .m_data  (held_item)
    );

    avtr_matcher u_matcher (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (held_valid && out_ready),
        .item    (held_item),
        .result  (result)
    );

    avtr_stage #(
        .W (AVTR_OUT_W)
    ) u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (held_valid),
        .s_ready (out_ready),
        .s_data  (result),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (out_result)
    );

    assign m_axis_tdata = out_result.data;
    assign m_axis_tlast = out_result.last;

    `AVTR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `AVTR_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    `AVTR_ASSERT_NEXT(a_last_carried, clk, rst_n, held_valid && out_ready,
        m_axis_tvalid && m_axis_tlast == $past(held_item.last))

endmodule

`default_nettype wire

// ===== verif/tb_audio_video_tag_rewriter.sv =====
`default_nettype none

module tb_audio_video_tag_rewriter
    import avtr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [AVTR_BYTE_W-1:0] s_axis_tdata = '0;   // in_byte
    logic                   s_axis_tuser = 1'b0; // new_stream
    logic                   s_axis_tlast = 1'b0; // chunk_last
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [AVTR_BYTE_W-1:0] m_axis_tdata;        // out_byte
    logic                   m_axis_tlast;        // chunk_end

    avtr_state_t  tag_state = ST_IDLE;
    avtr_result_t expected_bytes[$];
    avtr_result_t want;
    avtr_item_t   taken;
    int           error_count = 0;
    int           sender_idle_pct = 0;
    int           sink_stall_pct = 0;

    audio_video_tag_rewriter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb_audio_video_tag_rewriter: errors");
        $finish;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic avtr_result_t rewrite_byte(input avtr_item_t item);
        avtr_result_t res;
        avtr_state_t  s;
        logic [7:0]   c;
        c        = item.data;
        res.data = item.data;
        res.last = item.last;
        s        = item.restart ? ST_IDLE : tag_state;
        case (s)
            ST_LT:
            begin
                if (c == CH_A)
                    s = ST_A;
                else if (c == CH_V)
                    s = ST_V;
                else if (c == CH_BANG)
                    s = ST_BANG;
                else if (c != CH_SLASH)
                    s = ST_IDLE;
            end
            ST_A:     s = (c == CH_U)    ? ST_AU    : ST_IDLE;
            ST_AU:    s = (c == CH_D)    ? ST_AUD   : ST_IDLE;
            ST_AUD:   s = (c == CH_I)    ? ST_NAME  : ST_IDLE;
            ST_V:     s = (c == CH_I)    ? ST_VI    : ST_IDLE;
            ST_VI:    s = (c == CH_D)    ? ST_VID   : ST_IDLE;
            ST_VID:   s = (c == CH_E)    ? ST_NAME  : ST_IDLE;
            ST_NAME:
            begin
                if (c == CH_O)
                    res.data = CH_REPL;
                s = ST_IDLE;
            end
            ST_BANG:  s = (c == CH_LB)   ? ST_CD_LB : ST_IDLE;
            ST_CD_LB: s = (c == CH_UC_C) ? ST_CD_C  : ST_IDLE;
            ST_CD_C:  s = (c == CH_UC_D) ? ST_CD_D  : ST_IDLE;
            ST_CD_D:  s = (c == CH_UC_A) ? ST_CD_A  : ST_IDLE;
            ST_CD_A:  s = (c == CH_UC_T) ? ST_CD_T  : ST_IDLE;
            ST_CD_T:  s = (c == CH_UC_A) ? ST_CD_A2 : ST_IDLE;
            ST_CD_A2: s = (c == CH_LB)   ? ST_CDATA : ST_IDLE;
            ST_CDATA:
            begin
                if (c == CH_RB)
                    s = ST_RB1;
            end
            ST_RB1:   s = (c == CH_RB)   ? ST_RB2   : ST_CDATA;
            ST_RB2:   s = (c == CH_GT)   ? ST_IDLE  : ST_CDATA;
            default:  s = (c == CH_LT)   ? ST_LT    : ST_IDLE;
        endcase
        tag_state = s;
        return res;
    endfunction

    // compare each output transaction, then predict each input transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected output byte %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        $error("out_byte: expected %h, actual %h", want.data, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("chunk_end: expected %b, actual %b", want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken.data    = s_axis_tdata;
                taken.restart = s_axis_tuser;
                taken.last    = s_axis_tlast;
                expected_bytes.push_back(rewrite_byte(taken));
            end
        end
    end

    // enter and leave at a falling edge
    task automatic send_byte(input logic [7:0] data, input logic restart, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= restart;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_text(input string text, input logic restart);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], restart && (i == 0), i == text.len() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_tag_match();
        send_text("<audio", 1'b0);
        send_text("</video>", 1'b0);
        send_text("<//audio", 1'b0);
        wait_drained();
    endtask

    task automatic test_broken_match();
        // a '<' that breaks a partial match does not start a new one
        send_text("<au<audio", 1'b0);
        send_text("<vide", 1'b0);
        send_byte(CH_O, 1'b1, 1'b0);
        send_text("<audi", 1'b0);
        send_byte(CH_O | 8'h80, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_cdata();
        // a third ']' falls back into the section, so the first '>' does not close it
        send_text("<![CDATA[<video]]]>", 1'b0);
        send_text("]]><video", 1'b0);
        wait_drained();
    endtask

    task automatic test_random_markup(input int count, input int idle_pct, input int stall_pct);
        logic [7:0] frag[$];
        string      name;
        int         sent;
        int         n;
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        sent            = 0;
        while (sent < count)
        begin
            frag.delete();
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    name = $urandom_range(1) ? "audio" : "video";
                    frag.push_back(CH_LT);
                    n = $urandom_range(2);
                    repeat (n)
                        frag.push_back(CH_SLASH);
                    for (int i = 0; i < name.len(); i++)
                        frag.push_back(name[i]);
                    frag.push_back($urandom_range(1) ? CH_GT : 8'h20);
                end
                4, 5:
                begin
                    name = "<![CDATA[";
                    for (int i = 0; i < name.len(); i++)
                        frag.push_back(name[i]);
                    n = $urandom_range(8);
                    repeat (n)
                    begin
                        case ($urandom_range(5))
                            0, 1:    frag.push_back(CH_RB);
                            2:       frag.push_back(CH_GT);
                            3:       frag.push_back(CH_LT);
                            4:       frag.push_back(CH_O);
                            default: frag.push_back(8'($urandom_range(255)));
                        endcase
                    end
                    if ($urandom_range(1))
                        frag.push_back(CH_RB);
                    frag.push_back(CH_RB);
                    frag.push_back(CH_RB);
                    frag.push_back(CH_GT);
                end
                6, 7:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        frag.push_back(8'($urandom_range(255)));
                end
                default:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        frag.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
            endcase
            // corrupt a fragment now and then
            if ($urandom_range(4) == 0)
                frag[$urandom_range(frag.size() - 1)] = 8'($urandom_range(255));
            foreach (frag[i])
            begin
                send_byte(frag[i], $urandom_range(99) < 3, $urandom_range(99) < 10);
                sent++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_tag_match();
        test_broken_match();
        test_cdata();
        test_random_markup(150, 0, 0);
        test_random_markup(150, 52, 0);
        test_random_markup(150, 0, 52);
        test_random_markup(150, 7, 7);
        sink_stall_pct = 0;
        repeat (6)
            @(posedge clk);
        if (error_count == 0 && expected_bytes.size() == 0)
            $display("tb_audio_video_tag_rewriter: clean");
        else
            $display("tb_audio_video_tag_rewriter: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/avtr_pkg.sv
rtl/avtr_stage.sv
rtl/avtr_matcher.sv
rtl/audio_video_tag_rewriter.sv
verif/tb_audio_video_tag_rewriter.sv
